### design/firlt_pkg.sv
// Package for the loadable-tap FIR filter: sizes, control structs and the state encoding.
// It has no dependencies. The cell, the MAC and the top-level files import it.
`timescale 1ns / 1ps

package firlt_pkg;

    localparam int MAX_TAPS    = 64;
    localparam int CFG_W       = 7;
    localparam int TAP_IDX_W   = 6;
    localparam int COEF_W      = 18;
    localparam int SAMPLE_W    = 16;
    localparam int OUT_W       = 16;
    localparam int PROD_W      = COEF_W + SAMPLE_W;
    localparam int ACC_W       = PROD_W + $clog2(MAX_TAPS);
    localparam int CNT_W       = $clog2(MAX_TAPS);
    localparam int TAP_CNT_W   = $clog2(MAX_TAPS + 1);
    localparam int CMP_W       = (TAP_CNT_W > CFG_W) ? TAP_CNT_W : CFG_W;
    localparam int ROUND_SHIFT = 15;
    localparam int OUT_MAX     = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN     = -(1 << (OUT_W - 1));
    localparam int CFG_RESET   = 64;

    typedef struct packed {
        logic shift;   // Move every sample one cell toward the tail and take a new one.
        logic rotate;  // Move samples and taps one cell toward the head, wrapping around.
        logic clear;   // Zero the whole history.
    } cell_ctrl_t;

    typedef struct packed {
        logic clear;   // Zero the accumulator and drop any product in flight.
        logic prod_en; // The product being formed belongs to the sum.
    } mac_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_FLUSH = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    // Number of taps actually summed: zero counts as one, and the value is capped
    // at the table depth.
    function automatic logic [TAP_CNT_W-1:0] taps_used(input logic [CFG_W-1:0] cfg);
        logic [CMP_W-1:0] cfg_ext;
        cfg_ext = CMP_W'(cfg);
        if (cfg_ext == '0)
            return TAP_CNT_W'(1);
        else if (cfg_ext > CMP_W'(MAX_TAPS))
            return TAP_CNT_W'(MAX_TAPS);
        else
            return TAP_CNT_W'(cfg_ext);
    endfunction

endpackage

### design/firlt_cell.sv
// One cell of the filter chain: it holds one history sample and one coefficient.
// Depends on firlt_pkg for widths and the cell control struct.
`timescale 1ns / 1ps

module firlt_cell
    import firlt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_ctrl_t                 ctrl,
    input  logic                       tap_we,
    input  logic signed [COEF_W-1:0]   tap_wdata,
    input  logic signed [SAMPLE_W-1:0] prev_sample,
    input  logic signed [SAMPLE_W-1:0] next_sample,
    input  logic signed [COEF_W-1:0]   next_tap,
    output logic signed [SAMPLE_W-1:0] sample_q,
    output logic signed [COEF_W-1:0]   tap_q
);

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic signed [COEF_W-1:0]   tap_reg;
    logic signed [COEF_W-1:0]   tap_next;

    always_comb
    begin
        sample_next = sample_reg;
        if (ctrl.clear)
            sample_next = '0;
        else if (ctrl.shift)
            sample_next = prev_sample;
        else if (ctrl.rotate)
            sample_next = next_sample;
    end

    always_comb
    begin
        tap_next = tap_reg;
        if (tap_we)
            tap_next = tap_wdata;
        else if (ctrl.rotate)
            tap_next = next_tap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_reg <= '0;
        else
            sample_reg <= sample_next;
    end

    always_ff @(posedge clk)
    begin
        tap_reg <= tap_next;
    end

    assign sample_q = sample_reg;
    assign tap_q    = tap_reg;

endmodule

### design/firlt_mac.sv
// Shared multiply-accumulate with rounding and saturation of the finished sum.
// Depends on firlt_pkg for widths and the MAC control struct.
`timescale 1ns / 1ps

module firlt_mac
    import firlt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [COEF_W-1:0]   tap,
    output logic signed [OUT_W-1:0]    filtered,
    output logic                       saturated
);

    localparam int Y_W = ACC_W + 1 - ROUND_SHIFT;
    localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(OUT_MAX);
    localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(OUT_MIN);
    localparam logic signed [ACC_W:0] BIAS  = (ACC_W + 1)'(1 << (ROUND_SHIFT - 1));

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     pvalid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W:0]    biased;
    logic signed [Y_W-1:0]    y;

    assign prod_next = sample * tap;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
            acc_next = '0;
        else if (pvalid_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            pvalid_reg <= ctrl.prod_en && !ctrl.clear;
            acc_reg    <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Round half up, then floor by an arithmetic shift.
    assign biased = $signed({acc_reg[ACC_W-1], acc_reg}) + BIAS;
    assign y      = biased[ACC_W:ROUND_SHIFT];

    always_comb
    begin
        if (y > Y_MAX)
        begin
            filtered  = OUT_W'(OUT_MAX);
            saturated = 1'b1;
        end
        else if (y < Y_MIN)
        begin
            filtered  = OUT_W'(OUT_MIN);
            saturated = 1'b1;
        end
        else
        begin
            filtered  = y[OUT_W-1:0];
            saturated = 1'b0;
        end
    end

endmodule

### design/fir_filter_loadable_taps_unit.sv
// Top level of the loadable-tap FIR filter: control sequencer, cell chain and output register.
// Depends on firlt_pkg, firlt_cell and firlt_mac.
`timescale 1ns / 1ps

// A mode-0 transaction writes one Q3.15 coefficient into its cell.
// A mode-1 transaction shifts a Q1.15 sample into the history.
// Until the current signal has seen more samples than the active tap count, no result
// is produced and the next transaction is accepted in the following cycle.
// After that, each sample passes through S_RUN, S_FLUSH and S_DONE, with in_stall high,
// and S_DONE waits for the output register to free up. S_RUN rotates the history and
// tap rings once around the cell chain past the single shared multiply-accumulate,
// S_FLUSH lets the last registered product into the sum, and S_DONE rounds and loads the
// output. taps_in_use may be written whenever the filter is idle, and the new value
// applies from the next sample. The history is cleared after a sample flagged as
// last_sample. There is no clearing pass after reset.
module fir_filter_loadable_taps_unit
    import firlt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       mode,
    input  logic [TAP_IDX_W-1:0]       tap_index,
    input  logic signed [COEF_W-1:0]   coefficient,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last_sample,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [OUT_W-1:0]    filtered,
    output logic                       saturated
);

    state_t                  state_reg;
    state_t                  state_next;
    logic [CFG_W-1:0]        taps_in_use_reg;
    logic [TAP_CNT_W-1:0]    warm_reg;
    logic [TAP_CNT_W-1:0]    warm_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    last_reg;
    logic                    last_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [OUT_W-1:0] filtered_reg;
    logic                    saturated_reg;

    logic [TAP_CNT_W-1:0]    taps;
    logic                    accept;
    logic                    emit;
    logic                    out_free;
    logic                    out_load;
    cell_ctrl_t              cell_ctrl;
    mac_ctrl_t               mac_ctrl;
    logic [MAX_TAPS-1:0]     tap_we;

    logic signed [SAMPLE_W-1:0] sample_q [MAX_TAPS];
    logic signed [COEF_W-1:0]   tap_q    [MAX_TAPS];
    logic signed [OUT_W-1:0]    mac_filtered;
    logic                       mac_saturated;

    assign taps     = taps_used(taps_in_use_reg);
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign emit     = (warm_reg >= taps);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        for (int i = 0; i < MAX_TAPS; i++)
            tap_we[i] = accept && !mode && (int'(tap_index) == i);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        warm_next  = warm_reg;
        cell_ctrl  = '0;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept && mode)
                begin
                    cell_ctrl.shift = 1'b1;
                    last_next       = last_sample;
                    if (warm_reg < TAP_CNT_W'(MAX_TAPS))
                        warm_next = warm_reg + 1'b1;
                    if (emit)
                        state_next = S_RUN;
                    else if (last_sample)
                    begin
                        // No result is due, so the end of signal takes effect at once.
                        cell_ctrl.clear = 1'b1;
                        warm_next       = '0;
                    end
                end
            end
            S_RUN:
            begin
                cell_ctrl.rotate = 1'b1;
                cnt_next         = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAX_TAPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (last_reg)
                    begin
                        cell_ctrl.clear = 1'b1;
                        warm_next       = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign mac_ctrl.clear   = (state_reg == S_IDLE);
    assign mac_ctrl.prod_en = (state_reg == S_RUN) && (TAP_CNT_W'(cnt_reg) < taps);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            taps_in_use_reg <= CFG_W'(CFG_RESET);
            warm_reg        <= '0;
            cnt_reg         <= '0;
            last_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            warm_reg      <= warm_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                taps_in_use_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            filtered_reg  <= mac_filtered;
            saturated_reg <= mac_saturated;
        end
    end

    // Samples shift toward the tail on a new sample. During a run, samples and taps
    // both rotate toward the head, so cell 0 presents entry k while cnt_reg equals k.
    for (genvar g = 0; g < MAX_TAPS; g++)
    begin : g_cell
        firlt_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .tap_we      (tap_we[g]),
            .tap_wdata   (coefficient),
            .prev_sample ((g == 0) ? sample : sample_q[(g + MAX_TAPS - 1) % MAX_TAPS]),
            .next_sample (sample_q[(g + 1) % MAX_TAPS]),
            .next_tap    (tap_q[(g + 1) % MAX_TAPS]),
            .sample_q    (sample_q[g]),
            .tap_q       (tap_q[g])
        );
    end

    firlt_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .sample    (sample_q[0]),
        .tap       (tap_q[0]),
        .filtered  (mac_filtered),
        .saturated (mac_saturated)
    );

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign saturated = saturated_reg;

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared without a finished sum");

    a_warm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        warm_reg <= TAP_CNT_W'(MAX_TAPS))
        else $error("warm-up count beyond table depth");

    a_emit_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode && emit) |=> (state_reg == S_RUN) && (cnt_reg == '0))
        else $error("sample due a result did not start a run");

    a_full_rotation: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && cnt_reg != CNT_W'(MAX_TAPS - 1)) |=> (state_reg == S_RUN))
        else $error("run left before a full rotation");

endmodule
